// File: hw/rtl/positional_list_store_defines.svh
// Assertion macros for the positional list store.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef POSITIONAL_LIST_STORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define PLS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define PLS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/pls_pkg.sv
package pls_pkg;

  // Width of the position field, also used for cell indexes.
  localparam int IDX_W  = 8;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    OP_INS_FIRST = 3'd0,
    OP_INS_LAST  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FIRST = 3'd3,
    OP_DEL_LAST  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_DISPLAY   = 3'd6,
    OP_UNUSED    = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_IGNORED = 2'd1,
    STATUS_FULL    = 2'd2,
    STATUS_RSVD    = 2'd3
  } status_e;

  // Command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CMD_HOLD = 2'd0,
    CMD_INS  = 2'd1,
    CMD_DEL  = 2'd2,
    CMD_ROT  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

// File: hw/rtl/pls_cell.sv
module pls_cell #(
  parameter int INDEX = 0
) (
  input  logic                               clk_i,
  input  pls_pkg::cell_ctrl_t                ctrl_i,
  input  logic signed [pls_pkg::DATA_W-1:0]  left_i,
  input  logic signed [pls_pkg::DATA_W-1:0]  right_i,
  input  logic signed [pls_pkg::DATA_W-1:0]  head_i,
  output logic signed [pls_pkg::DATA_W-1:0]  data_o
);

  localparam logic [pls_pkg::IDX_W-1:0] MyIdx = pls_pkg::IDX_W'(INDEX);

  logic signed [pls_pkg::DATA_W-1:0] data_d, data_q;

  // Insert opens a gap at idx, delete closes it, rotate moves every
  // element one place toward the front and wraps the head to idx.
  always_comb begin
    data_d = data_q;
    unique case (ctrl_i.cmd)
      pls_pkg::CMD_INS: begin
        if (MyIdx == ctrl_i.idx) begin
          data_d = ctrl_i.value;
        end else if (MyIdx > ctrl_i.idx) begin
          data_d = left_i;
        end
      end
      pls_pkg::CMD_DEL: begin
        if (MyIdx >= ctrl_i.idx) begin
          data_d = right_i;
        end
      end
      pls_pkg::CMD_ROT: begin
        if (MyIdx == ctrl_i.idx) begin
          data_d = head_i;
        end else begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// File: hw/rtl/positional_list_store.sv
// Channel   Direction  Handshake               Payload
// request   in         in_valid_i/in_ready_o   op_i, value_i, position_i
// result    out        out_valid_o/out_ready_i status_o, count_o, item_o,
//                                              item_valid_o, last_o
//
// An edit updates the chain at the accepting edge and its single result is
// in the output register from the next cycle on. A display of N elements
// emits one element per cycle while the output is not stalled, the chain
// rotating one place per element; an empty list yields a lone empty result.
// Reset clears the element count, the sequencer and the output valid; the
// cells themselves are not reset and hold nothing readable until written.
// A stalled result holds the block: no new request and no further display
// step is taken until the output register is free.
module positional_list_store #(
  parameter int DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [2:0]                           op_i,
  input  logic signed [pls_pkg::DATA_W-1:0]    value_i,
  input  logic [pls_pkg::IDX_W-1:0]            position_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [1:0]                           status_o,
  output logic [$clog2(DEPTH+1)-1:0]           count_o,
  output logic signed [pls_pkg::DATA_W-1:0]    item_o,
  output logic                                 item_valid_o,
  output logic                                 last_o
);

`include "positional_list_store_defines.svh"

  localparam int CntW = $clog2(DEPTH + 1);
  // Compare width holds both the position and count + 1 without overflow.
  localparam int CmpW = ((CntW > pls_pkg::IDX_W) ? CntW : pls_pkg::IDX_W) + 1;
  localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DISP = 2'b10
  } state_e;

  state_e state_d, state_q;
  logic [CntW-1:0] cnt_d, cnt_q;
  logic [CntW-1:0] rem_d, rem_q;

  logic                              ovalid_d, ovalid_q;
  pls_pkg::status_e                  status_d, status_q;
  logic [CntW-1:0]                   ocnt_d, ocnt_q;
  logic signed [pls_pkg::DATA_W-1:0] item_d, item_q;
  logic                              ivalid_d, ivalid_q;
  logic                              last_d, last_q;

  pls_pkg::cell_ctrl_t ctrl;
  pls_pkg::op_e        op;

  logic signed [pls_pkg::DATA_W-1:0] cell_data [DEPTH];

  logic            out_free;
  logic            acc;
  logic [CmpW-1:0] cnt_x;
  logic [CmpW-1:0] pos_x;
  logic [CmpW-1:0] ins_pos;
  logic [CmpW-1:0] del_pos;
  logic            ins_bad;
  logic            del_bad;
  logic            full;

  // The output register is free when empty or when its result leaves now.
  assign out_free   = !ovalid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign acc        = in_valid_i && in_ready_o;

  assign op    = pls_pkg::op_e'(op_i);
  assign cnt_x = CmpW'(cnt_q);
  assign pos_x = CmpW'(position_i);
  assign full  = (cnt_q == DepthCnt);

  // Each edit resolves to a 1-based position; front and back ops fix it.
  always_comb begin
    ins_pos = pos_x;
    del_pos = pos_x;
    unique case (op) inside
      pls_pkg::OP_INS_FIRST: ins_pos = CmpW'(1);
      pls_pkg::OP_INS_LAST:  ins_pos = cnt_x + CmpW'(1);
      pls_pkg::OP_DEL_FIRST: del_pos = CmpW'(1);
      pls_pkg::OP_DEL_LAST:  del_pos = cnt_x;
      default: begin
        ins_pos = pos_x;
        del_pos = pos_x;
      end
    endcase
  end

  // A position is checked before fullness; an empty list fails every
  // delete because no position can be at most zero and nonzero.
  assign ins_bad = (ins_pos == '0) || (ins_pos > cnt_x + CmpW'(1));
  assign del_bad = (del_pos == '0) || (del_pos > cnt_x);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    ovalid_d   = ovalid_q && !out_ready_i;
    status_d   = status_q;
    ocnt_d     = ocnt_q;
    item_d     = item_q;
    ivalid_d   = ivalid_q;
    last_d     = last_q;
    ctrl.cmd   = pls_pkg::CMD_HOLD;
    ctrl.idx   = '0;
    ctrl.value = value_i;

    if (acc) begin
      // Every request answers at least one result right away.
      ovalid_d = 1'b1;
      status_d = pls_pkg::STATUS_DONE;
      ocnt_d   = cnt_q;
      item_d   = '0;
      ivalid_d = 1'b0;
      last_d   = 1'b1;
      unique case (op) inside
        pls_pkg::OP_INS_FIRST, pls_pkg::OP_INS_LAST, pls_pkg::OP_INS_AT: begin
          if (ins_bad) begin
            status_d = pls_pkg::STATUS_IGNORED;
          end else if (full) begin
            status_d = pls_pkg::STATUS_FULL;
          end else begin
            ctrl.cmd = pls_pkg::CMD_INS;
            ctrl.idx = pls_pkg::IDX_W'(ins_pos - CmpW'(1));
            cnt_d    = cnt_q + CntW'(1);
            ocnt_d   = cnt_q + CntW'(1);
          end
        end
        pls_pkg::OP_DEL_FIRST, pls_pkg::OP_DEL_LAST, pls_pkg::OP_DEL_AT: begin
          if (del_bad) begin
            status_d = pls_pkg::STATUS_IGNORED;
          end else begin
            ctrl.cmd = pls_pkg::CMD_DEL;
            ctrl.idx = pls_pkg::IDX_W'(del_pos - CmpW'(1));
            cnt_d    = cnt_q - CntW'(1);
            ocnt_d   = cnt_q - CntW'(1);
          end
        end
        pls_pkg::OP_DISPLAY: begin
          if (cnt_q != '0) begin
            // The head goes out now and the chain rotates behind it.
            item_d   = cell_data[0];
            ivalid_d = 1'b1;
            last_d   = (cnt_q == CntW'(1));
            ctrl.cmd = pls_pkg::CMD_ROT;
            ctrl.idx = pls_pkg::IDX_W'(cnt_q - CntW'(1));
            rem_d    = cnt_q - CntW'(1);
            if (cnt_q != CntW'(1)) begin
              state_d = ST_DISP;
            end
          end
        end
        default: status_d = pls_pkg::STATUS_IGNORED;
      endcase
    end else if ((state_q == ST_DISP) && out_free) begin
      // After count rotations the chain is back in its original order.
      ovalid_d = 1'b1;
      status_d = pls_pkg::STATUS_DONE;
      ocnt_d   = cnt_q;
      item_d   = cell_data[0];
      ivalid_d = 1'b1;
      last_d   = (rem_q == CntW'(1));
      ctrl.cmd = pls_pkg::CMD_ROT;
      ctrl.idx = pls_pkg::IDX_W'(cnt_q - CntW'(1));
      rem_d    = rem_q - CntW'(1);
      if (rem_q == CntW'(1)) begin
        state_d = ST_IDLE;
      end
    end
  end

  // The chain: each cell sees its neighbors and the head of the list.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [pls_pkg::DATA_W-1:0] left_w;
    logic signed [pls_pkg::DATA_W-1:0] right_w;

    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_w = cell_data[g];
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end

    pls_cell #(
      .INDEX(g)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .left_i (left_w),
      .right_i(right_w),
      .head_i (cell_data[0]),
      .data_o (cell_data[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      rem_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rem_q    <= rem_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    ocnt_q   <= ocnt_d;
    item_q   <= item_d;
    ivalid_q <= ivalid_d;
    last_q   <= last_d;
  end

  assign out_valid_o  = ovalid_q;
  assign status_o     = status_q;
  assign count_o      = ocnt_q;
  assign item_o       = item_q;
  assign item_valid_o = ivalid_q;
  assign last_o       = last_q;

  // The element count never leaves its range.
  `PLS_ASSERT_ALWAYS(a_cnt_range, cnt_q <= DepthCnt, "element count above depth")
  // While streaming, at least one element is still owed.
  `PLS_ASSERT_SAME(a_disp_rem, state_q == ST_DISP, rem_q != '0, "display with nothing left")
  // An edit answers with one closing result that carries no element.
  `PLS_ASSERT_NEXT(a_edit_result, acc && (op != pls_pkg::OP_DISPLAY),
    out_valid_o && last_o && !item_valid_o, "edit result missing or malformed")
  // A display of more than one element keeps the request side closed.
  `PLS_ASSERT_NEXT(a_disp_busy, acc && (op == pls_pkg::OP_DISPLAY) && (cnt_q > CntW'(1)),
    !in_ready_o && !last_o, "display stream ended early")

endmodule
